// File: hdl/rcfr_pkg.sv
// Package for the RC channel frame receiver.
// Frame constants and the structs passed between front, queue and back.
// No dependencies.
`default_nettype none

package rcfr_pkg;

    localparam int POS_W  = 5;
    localparam int CH_W   = 4;
    localparam int VAL_W  = 16;
    localparam int BYTE_W = 8;

    localparam int NUM_CHANNELS = 14;

    localparam logic [BYTE_W-1:0] SYNC_LEN_BYTE = 8'h20;
    localparam logic [BYTE_W-1:0] SYNC_CMD_BYTE = 8'h40;
    localparam logic [VAL_W-1:0]  SUM_INIT      = 16'hFFFF;

    // byte positions inside a frame
    localparam logic [POS_W-1:0] POS_HUNT     = 5'd0;
    localparam logic [POS_W-1:0] POS_CMD      = 5'd1;
    localparam logic [POS_W-1:0] POS_FIRST_HI = 5'd3;
    localparam logic [POS_W-1:0] POS_CK_LO    = 5'd30;  // also the first position past the summed bytes
    localparam logic [POS_W-1:0] POS_CK_HI    = 5'd31;

    localparam logic [CH_W-1:0] LAST_CH = 4'd13;

    // write port into the two-bank channel store
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [CH_W-1:0]   ch;
        logic [VAL_W-1:0]  data;
    } store_wr_t;

    // frame queue status seen by front and back
    typedef struct packed {
        logic not_full;
        logic not_empty;
        logic wr_bank;
        logic rd_bank;
    } fq_status_t;

endpackage

`default_nettype wire

// File: hdl/rcfr_queue.sv
// Two-entry queue of completed frames; each entry owns one store bank.
// Depends on rcfr_pkg.
`default_nettype none

module rcfr_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic             pop,
    output rcfr_pkg::fq_status_t  status
);

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign status.not_full  = (count_reg != 2'd2);
    assign status.not_empty = (count_reg != 2'd0);
    assign status.wr_bank   = wr_ptr_reg;
    assign status.rd_bank   = rd_ptr_reg;

endmodule

`default_nettype wire

// File: hdl/rcfr_front.sv
// Front end: frame hunt, checksum and channel collection, one byte per cycle while s_ready is high.
// Depends on rcfr_pkg.
`default_nettype none

module rcfr_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rcfr_pkg::BYTE_W-1:0]   s_rx_byte,
    input  wire rcfr_pkg::fq_status_t          status,
    output rcfr_pkg::store_wr_t                store_wr,
    output logic                               push
);

    logic [rcfr_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [rcfr_pkg::VAL_W-1:0]  sum_reg, sum_next;
    logic [rcfr_pkg::BYTE_W-1:0] low_reg, low_next;
    logic [rcfr_pkg::POS_W-1:0]  ch_off;
    logic                        accept;

    // a frame may only be collected into a bank that is not waiting to drain
    assign s_ready = status.not_full;
    assign accept  = s_valid && s_ready;
    assign ch_off  = pos_reg - rcfr_pkg::POS_FIRST_HI;

    always_comb begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        low_next      = low_reg;
        push          = 1'b0;
        store_wr.en   = 1'b0;
        store_wr.bank = status.wr_bank;
        store_wr.ch   = ch_off[rcfr_pkg::POS_W-1:1];
        store_wr.data = {s_rx_byte, low_reg};
        if (accept) begin
            priority if (pos_reg == rcfr_pkg::POS_HUNT) begin
                if (s_rx_byte == rcfr_pkg::SYNC_LEN_BYTE) begin
                    sum_next = rcfr_pkg::SUM_INIT - {8'h00, s_rx_byte};
                    pos_next = rcfr_pkg::POS_CMD;
                end
            end else if (pos_reg == rcfr_pkg::POS_CMD) begin
                if (s_rx_byte == rcfr_pkg::SYNC_CMD_BYTE) begin
                    sum_next = sum_reg - {8'h00, s_rx_byte};
                    pos_next = pos_reg + 5'd1;
                end else begin
                    sum_next = rcfr_pkg::SUM_INIT;
                    pos_next = rcfr_pkg::POS_HUNT;
                end
            end else if (pos_reg < rcfr_pkg::POS_CK_LO) begin
                sum_next = sum_reg - {8'h00, s_rx_byte};
                if (!pos_reg[0]) begin
                    low_next = s_rx_byte;
                end else begin
                    store_wr.en = 1'b1;  // high byte completes a channel
                end
                pos_next = pos_reg + 5'd1;
            end else if (pos_reg == rcfr_pkg::POS_CK_LO) begin
                low_next = s_rx_byte;
                pos_next = rcfr_pkg::POS_CK_HI;
            end else begin
                push     = ({s_rx_byte, low_reg} == sum_reg);
                sum_next = rcfr_pkg::SUM_INIT;
                pos_next = rcfr_pkg::POS_HUNT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= rcfr_pkg::POS_HUNT;
            sum_reg <= rcfr_pkg::SUM_INIT;
            low_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            low_reg <= low_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rcfr_back.sv
// Back end: two-bank channel store and the result emitter.
// Depends on rcfr_pkg.
`default_nettype none

module rcfr_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rcfr_pkg::store_wr_t           store_wr,
    input  wire rcfr_pkg::fq_status_t          status,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [rcfr_pkg::CH_W-1:0]          m_channel_number,
    output logic [rcfr_pkg::VAL_W-1:0]         m_channel_value,
    output logic                               m_last_channel
);

    logic [rcfr_pkg::VAL_W-1:0] mem_reg [0:1][0:rcfr_pkg::NUM_CHANNELS-1];

    logic [rcfr_pkg::CH_W-1:0]  ch_reg, ch_next;
    logic                       m_valid_reg, m_valid_next;
    logic [rcfr_pkg::CH_W-1:0]  m_num_reg;
    logic [rcfr_pkg::VAL_W-1:0] m_val_reg;
    logic                       m_last_reg;
    logic                       load;

    always_ff @(posedge aclk) begin
        if (store_wr.en) begin
            mem_reg[store_wr.bank][store_wr.ch] <= store_wr.data;
        end
    end

    // the output register doubles as the store's read register
    assign load = status.not_empty && (!m_valid_reg || m_ready);
    assign pop  = load && (ch_reg == rcfr_pkg::LAST_CH);

    always_comb begin
        ch_next      = ch_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            ch_next      = pop ? '0 : ch_reg + 4'd1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ch_reg      <= ch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_val_reg  <= mem_reg[status.rd_bank][ch_reg];
            m_num_reg  <= ch_reg + 4'd1;
            m_last_reg <= (ch_reg == rcfr_pkg::LAST_CH);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_channel_number = m_num_reg;
    assign m_channel_value  = m_val_reg;
    assign m_last_channel   = m_last_reg;

endmodule

`default_nettype wire

// File: hdl/rc_channel_frame_receiver.sv
// RC channel frame receiver, top level.
// Input channel (s_): one received serial byte per item in s_rx_byte.
// Output channel (m_): one channel result per item: m_channel_number (1..14),
//   m_channel_value, and m_last_channel on the fourteenth result of a frame.
// The block hunts for a 32-byte frame (0x20, 0x40, 14 little-endian
// channels, little-endian checksum) and emits 14 results for each frame
// whose checksum matches; bad frames are dropped without any output.
// The front end accepts bytes back to back while s_ready is high. The
// queue count is registered when a good frame's last byte is accepted, and
// then, if no earlier frame is still draining, the output register loads
// the first result; the rest leave at one per cycle while m_ready is high.
// Channel values sit in a two-bank store handed over through a two-entry
// frame queue: the front end keeps taking bytes while the back end drains.
// s_ready drops only while both queue entries hold good frames not yet drained.
// A stalled m_ready holds the current result stable and stops draining.
// aresetn (synchronous, active low) returns to the hunt and discards any
// frames still queued; no clearing pass is needed.
// Depends on rcfr_pkg, rcfr_front, rcfr_queue and rcfr_back.
`default_nettype none

module rc_channel_frame_receiver (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_rx_byte,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [3:0]         m_channel_number,
    output logic [15:0]        m_channel_value,
    output logic               m_last_channel
);

    rcfr_pkg::fq_status_t status;
    rcfr_pkg::store_wr_t  store_wr;
    logic                 push;
    logic                 pop;

    rcfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .status    (status),
        .store_wr  (store_wr),
        .push      (push)
    );

    rcfr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .status  (status)
    );

    rcfr_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .store_wr         (store_wr),
        .status           (status),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_channel_number (m_channel_number),
        .m_channel_value  (m_channel_value),
        .m_last_channel   (m_last_channel)
    );

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench for rc_channel_frame_receiver: drives byte streams of good, broken and noisy
// frames, predicts the channel results in a scoreboard class and checks each one.
// Depends on rcfr_pkg and the RTL of rc_channel_frame_receiver.
`timescale 1ns / 100ps

module tb;

    localparam int FRAME_BYTES      = 32;
    localparam int SUMMED_BYTES     = 30;
    localparam int TOTAL_BYTES      = 380;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 40;
    localparam int IDLE_PCT         = 18;

    typedef enum int {CK_RIGHT, CK_LOW_WRONG, CK_HIGH_WRONG} ck_mode_t;

    typedef logic [rcfr_pkg::CH_W-1:0]  ch_num_t;
    typedef logic [rcfr_pkg::VAL_W-1:0] chan_val_t;

    typedef struct packed {
        ch_num_t   num;
        chan_val_t value;
        logic      last;
    } chan_result_t;

    // Tracks the frame state of the block and holds the channel results still due.
    class channel_tracker;
        logic [rcfr_pkg::POS_W-1:0] byte_pos;
        chan_val_t                  sum_left;
        logic [7:0]                 low_hold;
        chan_val_t                  chan_vals [rcfr_pkg::NUM_CHANNELS];
        chan_result_t               due_results [$];
        int                         errors;

        function new();
            byte_pos = rcfr_pkg::POS_HUNT;
            sum_left = rcfr_pkg::SUM_INIT;
            low_hold = 8'h00;
            errors   = 0;
            foreach (chan_vals[i]) chan_vals[i] = '0;
        endfunction

        // Returns 1 when the byte moved the frame state, 0 when it was ignored.
        function bit absorb_byte(logic [7:0] b);
            int ch;
            if (byte_pos == rcfr_pkg::POS_HUNT) begin
                if (b != rcfr_pkg::SYNC_LEN_BYTE) return 1'b0;
                sum_left = rcfr_pkg::SUM_INIT - b;
                byte_pos = rcfr_pkg::POS_CMD;
                return 1'b1;
            end
            if (byte_pos == rcfr_pkg::POS_CMD) begin
                if (b == rcfr_pkg::SYNC_CMD_BYTE) begin
                    sum_left = sum_left - b;
                    byte_pos = byte_pos + 1'b1;
                end else begin
                    // the bad command byte is not rechecked as a length byte
                    byte_pos = rcfr_pkg::POS_HUNT;
                    sum_left = rcfr_pkg::SUM_INIT;
                end
                return 1'b1;
            end
            if (byte_pos < rcfr_pkg::POS_CK_LO) begin
                sum_left = sum_left - b;
                if (!byte_pos[0]) begin
                    low_hold = b;
                end else begin
                    ch = (int'(byte_pos) - int'(rcfr_pkg::POS_FIRST_HI)) / 2;
                    chan_vals[ch] = {b, low_hold};
                end
                byte_pos = byte_pos + 1'b1;
                return 1'b1;
            end
            if (byte_pos == rcfr_pkg::POS_CK_LO) begin
                low_hold = b;
                byte_pos = rcfr_pkg::POS_CK_HI;
                return 1'b1;
            end
            if ({b, low_hold} == sum_left) begin
                for (int i = 0; i < rcfr_pkg::NUM_CHANNELS; i++)
                    due_results.push_back('{num: ch_num_t'(i + 1), value: chan_vals[i],
                                            last: (i == int'(rcfr_pkg::LAST_CH))});
            end
            byte_pos = rcfr_pkg::POS_HUNT;
            sum_left = rcfr_pkg::SUM_INIT;
            return 1'b1;
        endfunction

        task note_mismatch(string msg);
            errors++;
            $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_result(ch_num_t num, chan_val_t value, logic last);
            chan_result_t want;
            if (due_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result ch %0d value %h last %b",
                                        num, value, last));
                return;
            end
            want = due_results.pop_front();
            if (num !== want.num)
                note_mismatch($sformatf("channel number %0d, want %0d", num, want.num));
            if (value !== want.value)
                note_mismatch($sformatf("ch %0d value %h, want %h", want.num, value,
                                        want.value));
            if (last !== want.last)
                note_mismatch($sformatf("ch %0d last flag %b, want %b", want.num, last,
                                        want.last));
        endtask
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_rx_byte = 8'h00;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [3:0]       m_channel_number;
    logic [15:0]      m_channel_value;
    logic             m_last_channel;

    channel_tracker tracker = new();
    bit src_idle_ok  = 1'b1;
    bit sink_idle_ok = 1'b1;
    bit hold_request = 1'b0;
    int sent_bytes   = 0;

    rc_channel_frame_receiver dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_channel_number (m_channel_number),
        .m_channel_value  (m_channel_value),
        .m_last_channel   (m_last_channel)
    );

    always #1 aclk = ~aclk;

    initial begin
        #200000;
        $display("tb NOT OK");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while (src_idle_ok && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        void'(tracker.absorb_byte(b));
        sent_bytes++;
    endtask

    // Sends the first cut_len bytes of a frame carrying vals.
    task automatic send_frame(input chan_val_t vals [rcfr_pkg::NUM_CHANNELS],
                              input logic [7:0] cmd, input ck_mode_t ck_mode,
                              input int cut_len);
        logic [7:0] fb [FRAME_BYTES];
        chan_val_t  ck;
        fb[0] = rcfr_pkg::SYNC_LEN_BYTE;
        fb[1] = cmd;
        for (int i = 0; i < rcfr_pkg::NUM_CHANNELS; i++) begin
            fb[2 + 2*i] = vals[i][7:0];
            fb[3 + 2*i] = vals[i][15:8];
        end
        ck = rcfr_pkg::SUM_INIT;
        for (int k = 0; k < SUMMED_BYTES; k++) ck = ck - fb[k];
        fb[30] = ck[7:0];
        fb[31] = ck[15:8];
        if (ck_mode == CK_LOW_WRONG)  fb[30] = fb[30] ^ 8'($urandom_range(1, 255));
        if (ck_mode == CK_HIGH_WRONG) fb[31] = fb[31] ^ 8'($urandom_range(1, 255));
        for (int k = 0; k < cut_len; k++) send_byte(fb[k]);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.due_results.size() != 0);
    endtask

    function automatic chan_val_t pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return chan_val_t'($urandom_range(1000, 2000));
            default: return chan_val_t'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic fill_random(output chan_val_t vals [rcfr_pkg::NUM_CHANNELS]);
        foreach (vals[i]) vals[i] = pick_value();
    endtask

    // result side: check, then choose ready for the next edge
    initial begin
        int hold_left;
        hold_left = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                tracker.check_result(m_channel_number, m_channel_value, m_last_channel);
            if (hold_request) begin
                hold_left    = SINK_HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (sink_idle_ok && $urandom_range(99) < IDLE_PCT) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        chan_val_t  vals [rcfr_pkg::NUM_CHANNELS];
        logic [7:0] bad_cmd;
        int         pick;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // noise while hunting is ignored
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(rcfr_pkg::SYNC_CMD_BYTE);

        // both sides busy on every cycle for a stretch
        src_idle_ok  = 1'b0;
        sink_idle_ok = 1'b0;
        foreach (vals[i]) vals[i] = '1;
        send_frame(vals, rcfr_pkg::SYNC_CMD_BYTE, CK_RIGHT, FRAME_BYTES);
        foreach (vals[i]) vals[i] = chan_val_t'(1) << i;
        vals[rcfr_pkg::LAST_CH] = 16'h8000;
        send_frame(vals, rcfr_pkg::SYNC_CMD_BYTE, CK_RIGHT, FRAME_BYTES);
        src_idle_ok  = 1'b1;
        sink_idle_ok = 1'b1;

        send_frame(vals, rcfr_pkg::SYNC_CMD_BYTE, CK_LOW_WRONG, FRAME_BYTES);
        send_frame(vals, rcfr_pkg::SYNC_CMD_BYTE, CK_HIGH_WRONG, FRAME_BYTES);
        // length byte seen twice: the second one is a bad command, not a new start
        fill_random(vals);
        send_frame(vals, rcfr_pkg::SYNC_LEN_BYTE, CK_RIGHT, FRAME_BYTES);
        fill_random(vals);
        send_frame(vals, rcfr_pkg::SYNC_CMD_BYTE, CK_RIGHT, FRAME_BYTES);

        // sink stalls while good frames keep coming, so the input backs up
        src_idle_ok  = 1'b0;
        hold_request = 1'b1;
        repeat (3) begin
            fill_random(vals);
            send_frame(vals, rcfr_pkg::SYNC_CMD_BYTE, CK_RIGHT, FRAME_BYTES);
        end
        src_idle_ok = 1'b1;
        wait_results_drained();

        while (sent_bytes < TOTAL_BYTES) begin
            fill_random(vals);
            pick = $urandom_range(99);
            if (pick < 62) begin
                send_frame(vals, rcfr_pkg::SYNC_CMD_BYTE, CK_RIGHT, FRAME_BYTES);
            end else if (pick < 70) begin
                send_frame(vals, rcfr_pkg::SYNC_CMD_BYTE, CK_LOW_WRONG, FRAME_BYTES);
            end else if (pick < 76) begin
                send_frame(vals, rcfr_pkg::SYNC_CMD_BYTE, CK_HIGH_WRONG, FRAME_BYTES);
            end else if (pick < 84) begin
                bad_cmd = 8'($urandom_range(0, 255));
                if (bad_cmd == rcfr_pkg::SYNC_CMD_BYTE) bad_cmd = rcfr_pkg::SYNC_LEN_BYTE;
                send_frame(vals, bad_cmd, CK_RIGHT, $urandom_range(2, FRAME_BYTES));
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                // frame cut short; following bytes get absorbed into it
                send_frame(vals, rcfr_pkg::SYNC_CMD_BYTE, CK_RIGHT,
                           $urandom_range(2, FRAME_BYTES - 1));
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
hdl/rcfr_pkg.sv
hdl/rcfr_queue.sv
hdl/rcfr_front.sv
hdl/rcfr_back.sv
hdl/rc_channel_frame_receiver.sv
dv/tb.sv
